// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL, included by the hash top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/sha_vr_pkg.sv =====
// Types, constants and round functions for the variable-round hash.
package sha_vr_pkg;
	localparam int unsigned WordW = 32;
	typedef logic [WordW-1:0] word_t;
	typedef word_t [7:0] chain_t;

	localparam chain_t Iv256 = {
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};
	localparam chain_t Iv224 = {
		32'hBEFA4FA4, 32'h64F98FA7, 32'h68581511, 32'hFFC00B31,
		32'hF70E5939, 32'h3070DD17, 32'h367CD507, 32'hC1059ED8};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [0:0] CfgRounds = 1'b0;
	localparam logic [0:0] CfgDigest = 1'b1;

	function automatic word_t round_k(input logic [6:0] i);
		word_t k;
		unique case (i)
			7'd0: k = 32'h428A2F98; 7'd1: k = 32'h71374491; 7'd2: k = 32'hB5C0FBCF;
			7'd3: k = 32'hE9B5DBA5; 7'd4: k = 32'h3956C25B; 7'd5: k = 32'h59F111F1;
			7'd6: k = 32'h923F82A4; 7'd7: k = 32'hAB1C5ED5; 7'd8: k = 32'hD807AA98;
			7'd9: k = 32'h12835B01; 7'd10: k = 32'h243185BE; 7'd11: k = 32'h550C7DC3;
			7'd12: k = 32'h72BE5D74; 7'd13: k = 32'h80DEB1FE; 7'd14: k = 32'h9BDC06A7;
			7'd15: k = 32'hC19BF174; 7'd16: k = 32'hE49B69C1; 7'd17: k = 32'hEFBE4786;
			7'd18: k = 32'h0FC19DC6; 7'd19: k = 32'h240CA1CC; 7'd20: k = 32'h2DE92C6F;
			7'd21: k = 32'h4A7484AA; 7'd22: k = 32'h5CB0A9DC; 7'd23: k = 32'h76F988DA;
			7'd24: k = 32'h983E5152; 7'd25: k = 32'hA831C66D; 7'd26: k = 32'hB00327C8;
			7'd27: k = 32'hBF597FC7; 7'd28: k = 32'hC6E00BF3; 7'd29: k = 32'hD5A79147;
			7'd30: k = 32'h06CA6351; 7'd31: k = 32'h14292967; 7'd32: k = 32'h27B70A85;
			7'd33: k = 32'h2E1B2138; 7'd34: k = 32'h4D2C6DFC; 7'd35: k = 32'h53380D13;
			7'd36: k = 32'h650A7354; 7'd37: k = 32'h766A0ABB; 7'd38: k = 32'h81C2C92E;
			7'd39: k = 32'h92722C85; 7'd40: k = 32'hA2BFE8A1; 7'd41: k = 32'hA81A664B;
			7'd42: k = 32'hC24B8B70; 7'd43: k = 32'hC76C51A3; 7'd44: k = 32'hD192E819;
			7'd45: k = 32'hD6990624; 7'd46: k = 32'hF40E3585; 7'd47: k = 32'h106AA070;
			7'd48: k = 32'h19A4C116; 7'd49: k = 32'h1E376C08; 7'd50: k = 32'h2748774C;
			7'd51: k = 32'h34B0BCB5; 7'd52: k = 32'h391C0CB3; 7'd53: k = 32'h4ED8AA4A;
			7'd54: k = 32'h5B9CCA4F; 7'd55: k = 32'h682E6FF3; 7'd56: k = 32'h748F82EE;
			7'd57: k = 32'h78A5636F; 7'd58: k = 32'h84C87814; 7'd59: k = 32'h8CC70208;
			7'd60: k = 32'h90BEFFFA; 7'd61: k = 32'hA4506CEB; 7'd62: k = 32'hBEF9A3F7;
			7'd63: k = 32'hC67178F2; 7'd64: k = 32'hCA273ECE; 7'd65: k = 32'hD186B8C7;
			7'd66: k = 32'hEADA7DD6; 7'd67: k = 32'hF57D4F7F; 7'd68: k = 32'h06F067AA;
			7'd69: k = 32'h0A637DC5; 7'd70: k = 32'h113F9804; 7'd71: k = 32'h1B710B35;
			7'd72: k = 32'h28DB77F5; 7'd73: k = 32'h32CAAB7B; 7'd74: k = 32'h3C9EBE0A;
			7'd75: k = 32'h431D67C4; 7'd76: k = 32'h4CC5D4BE; 7'd77: k = 32'h597F299C;
			7'd78: k = 32'h5FCB6FAB; 7'd79: k = 32'h6C44198C; 7'd80: k = 32'h7BA0EA2D;
			7'd81: k = 32'h7EABF2D0; 7'd82: k = 32'h8DBE8D03; 7'd83: k = 32'h90BB1721;
			7'd84: k = 32'h99A2AD45; 7'd85: k = 32'h9F86E289; 7'd86: k = 32'hA84C4472;
			7'd87: k = 32'hB3DF34FC; 7'd88: k = 32'hB99BB8D7; 7'd89: k = 32'hBC76CBAB;
			7'd90: k = 32'hC226A69A; 7'd91: k = 32'hD304F19A; 7'd92: k = 32'hDE1BE20A;
			7'd93: k = 32'hE39BB437; 7'd94: k = 32'hEE84927C; 7'd95: k = 32'hF3EDD277;
			7'd96: k = 32'hFBFDFE53; 7'd97: k = 32'h0BEE2C7A; 7'd98: k = 32'h0E90181C;
			7'd99: k = 32'h25F57204; 7'd100: k = 32'h2DA45582; 7'd101: k = 32'h3A52C34C;
			7'd102: k = 32'h41DC0172; 7'd103: k = 32'h495796FC; 7'd104: k = 32'h4BD31FC6;
			7'd105: k = 32'h533CDE21; 7'd106: k = 32'h5F7ABFE3; 7'd107: k = 32'h66C206B3;
			7'd108: k = 32'h6DFCC6BC; 7'd109: k = 32'h7062F20F; 7'd110: k = 32'h778D5127;
			7'd111: k = 32'h7EABA3CC; 7'd112: k = 32'h8363ECCC; 7'd113: k = 32'h85BE1C25;
			7'd114: k = 32'h93C04028; 7'd115: k = 32'h9F4A205F; 7'd116: k = 32'hA1953565;
			7'd117: k = 32'hA627BB0F; 7'd118: k = 32'hACFA8089; 7'd119: k = 32'hB3C29B23;
			7'd120: k = 32'hB602F6FA; 7'd121: k = 32'hC36CEE0A; 7'd122: k = 32'hC7DC81EE;
			7'd123: k = 32'hCE7B8471; 7'd124: k = 32'hD740288C; 7'd125: k = 32'hE21DBA7A;
			7'd126: k = 32'hEABBFF66; 7'd127: k = 32'hF56A9E60;
			default: k = '0;
		endcase
		return k;
	endfunction
endpackage

// ===== rtl/sha256_variable_round_hash_top.sv =====
// Top level of the byte-serial SHA-2 hash with variable round count.
// Channel | Dir | Payload
// s_axis  | in  | tdata[7:0] data_byte, tdata[8] byte_present; tlast message_end
// m_axis  | out | tdata[7:0] digest_byte; tlast digest_last
// cfg     | in  | index 0 round_setting, index 1 digest_bytes
// Bytes that do not fill a block are taken one per cycle; a full block is loaded
// into the shared round unit, run for the set rounds, then folded into the chain.
// The end mark adds padding bytes one per cycle (up to two blocks), then the
// digest goes out one byte per cycle, stalled while m_axis_tready is low.
// No clearing pass after reset; input is refused while a block or digest runs.
`include "assert_macros.svh"
module sha256_variable_round_hash_top #(
	parameter int unsigned MAX_ROUNDS = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [15:0] s_axis_tdata, // [7:0] data_byte, [8] byte_present
	input  logic       s_axis_tlast,  // message_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] digest_byte
	output logic       m_axis_tlast,  // digest_last
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata
);
	import sha_vr_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StPad  = 3'd1;
	localparam logic [2:0] StLoad = 3'd2;
	localparam logic [2:0] StRnd  = 3'd3;
	localparam logic [2:0] StFold = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;

	logic [2:0] st_q;
	logic [7:0] rset_q;
	logic [5:0] dbytes_q;
	chain_t chain_q;
	word_t buf_q [16];
	logic [5:0] fill_q;
	logic [63:0] blen_q;
	logic open_q, ending_q;
	logic [6:0] rnd_q;
	logic [2:0] fold_q;
	logic [5:0] ocnt_q;
	logic [7:0] obyte_q;
	logic olast_q, ovalid_q;
	word_t rd_q;
	chain_t vars;
	word_t wnew;
	logic [7:0] rounds;
	logic [7:0] padb;
	logic [5:0] nout;
	logic acc, has_byte, oload;

	always_comb begin
		if (rset_q == 8'd0) rounds = 8'd64;
		else if (rset_q <= 8'd16) rounds = 8'd16;
		else rounds = (rset_q + 8'd7) & 8'hF8;
		if (rset_q > 8'd248) rounds = 8'(MAX_ROUNDS);
		if (rounds > 8'(MAX_ROUNDS)) rounds = 8'(MAX_ROUNDS);
	end

	assign nout = (dbytes_q > 6'd32) ? 6'd32 : dbytes_q;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign has_byte = s_axis_tdata[8];
	assign s_axis_tready = (st_q == StIdle);
	assign oload = (st_q == StOut) && (nout != 6'd0) && (!ovalid_q || m_axis_tready);

	// ending_q: first pad cycle writes 0x80; pend_q flags an end pending after a block
	logic pend_q, final_q, spill_q;

	// padding byte for the current fill position
	always_comb begin
		if (fill_q >= 6'd56) padb = 8'(blen_q >> (7'd8 * (7'd63 - {1'b0, fill_q})));
		else padb = 8'd0;
	end

	// schedule word read over the buffer: registered word read ahead of the round
	assign wnew = rd_q;

	always_ff @(posedge clk) begin
		logic [6:0] nidx;
		nidx = (st_q == StLoad) ? 7'd0 : rnd_q + 7'd1;
		if (acc && has_byte) begin
			buf_q[fill_q[5:2]][{~fill_q[1:0], 3'd0} +: 8] <= s_axis_tdata[7:0];
		end else if (st_q == StPad) begin
			buf_q[fill_q[5:2]][{~fill_q[1:0], 3'd0} +: 8] <=
				(ending_q) ? PadByte : ((spill_q) ? 8'd0 : padb);
		end
		if (nidx < 7'd16) rd_q <= buf_q[nidx[3:0]];
	end

	sha_vr_round u_round (
		.clk      (clk),
		.load     (st_q == StLoad),
		.step     (st_q == StRnd),
		.idx      (rnd_q),
		.chain_in (chain_q),
		.wnew     (wnew),
		.vars     (vars)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			rset_q <= '0;
			dbytes_q <= 6'd32;
			chain_q <= Iv256;
			fill_q <= '0;
			blen_q <= '0;
			open_q <= 1'b0;
			ending_q <= 1'b0;
			pend_q <= 1'b0;
			final_q <= 1'b0;
			spill_q <= 1'b0;
			rnd_q <= '0;
			fold_q <= '0;
			ocnt_q <= '0;
			ovalid_q <= 1'b0;
			olast_q <= 1'b0;
			obyte_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CfgRounds: rset_q <= cfg_wdata;
					CfgDigest: begin
						dbytes_q <= cfg_wdata[5:0];
						if (!open_q) chain_q <= (cfg_wdata[5:0] > 6'd28) ? Iv256 : Iv224;
					end
					default: ;
				endcase
			end
			if (oload) ovalid_q <= 1'b1;
			else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			unique case (st_q)
				StIdle: begin
					if (acc) begin
						if (has_byte) begin
							fill_q <= fill_q + 6'd1;
							blen_q <= blen_q + 64'd8;
							open_q <= 1'b1;
						end
						if (has_byte && fill_q == 6'd63) begin
							st_q <= StLoad;
							pend_q <= s_axis_tlast;
						end else if (s_axis_tlast) begin
							ending_q <= 1'b1;
							st_q <= StPad;
						end
					end
				end
				StPad: begin
					ending_q <= 1'b0;
					fill_q <= fill_q + 6'd1;
					// no room left for the length: zero this block and pad one more
					if (ending_q && fill_q >= 6'd56) spill_q <= 1'b1;
					if (fill_q == 6'd63) begin
						st_q <= StLoad;
						if (!(spill_q || (ending_q && fill_q >= 6'd56))) final_q <= 1'b1;
					end
				end
				StLoad: begin
					rnd_q <= '0;
					st_q <= StRnd;
				end
				StRnd: begin
					rnd_q <= rnd_q + 7'd1;
					if ({1'b0, rnd_q} + 8'd1 == rounds) begin
						fold_q <= '0;
						st_q <= StFold;
					end
				end
				StFold: begin
					chain_q[fold_q] <= chain_q[fold_q] + vars[fold_q];
					fold_q <= fold_q + 3'd1;
					if (fold_q == 3'd7) begin
						if (pend_q) begin
							pend_q <= 1'b0;
							ending_q <= 1'b1;
							st_q <= StPad;
						end else if (spill_q) begin
							spill_q <= 1'b0;
							st_q <= StPad;
						end else if (final_q) begin
							final_q <= 1'b0;
							ocnt_q <= '0;
							st_q <= StOut;
						end else begin
							st_q <= StIdle;
						end
					end
				end
				StOut: begin
					if (nout == 6'd0) begin
						chain_q <= (dbytes_q > 6'd28) ? Iv256 : Iv224;
						blen_q <= '0; fill_q <= '0; open_q <= 1'b0;
						st_q <= StIdle;
					end else if (oload) begin
						obyte_q <= 8'(chain_q[ocnt_q[4:2]] >> (5'd24 - {ocnt_q[1:0], 3'd0}));
						olast_q <= (ocnt_q + 6'd1 == nout);
						ocnt_q <= ocnt_q + 6'd1;
						if (ocnt_q + 6'd1 == nout) begin
							chain_q <= (dbytes_q > 6'd28) ? Iv256 : Iv224;
							blen_q <= '0; fill_q <= '0; open_q <= 1'b0;
							st_q <= StIdle;
						end
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = obyte_q;
	assign m_axis_tlast = olast_q;

	`ASSERT_NEVER(a_no_accept_busy, clk, arst_n, acc && st_q != StIdle, "accept while busy")
	`ASSERT_CLK(a_round_bound, clk, arst_n, (st_q == StRnd) |-> ({1'b0, rnd_q} < rounds), "round overrun")
	`ASSERT_CLK(a_out_hold, clk, arst_n, (ovalid_q && !m_axis_tready) |=> $stable(obyte_q), "digest byte dropped")
endmodule

// ===== rtl/sha_vr_round.sv =====
// Shared compression round unit: one SHA-2 round and one schedule step per cycle while step is high.
module sha_vr_round (
	input  logic                 clk,
	input  logic                 load,
	input  logic                 step,
	input  logic [6:0]           idx,
	input  sha_vr_pkg::chain_t   chain_in,
	input  sha_vr_pkg::word_t    wnew,
	output sha_vr_pkg::chain_t   vars
);
	import sha_vr_pkg::*;

	word_t w_q [16];
	chain_t v_q;
	word_t wx, wy, s0, s1, wi, t1, t2, sig1, sig0, ch, maj;
	logic [3:0] i0, i1, i9, i14;

	assign i0  = idx[3:0];
	assign i1  = idx[3:0] + 4'd1;
	assign i9  = idx[3:0] + 4'd9;
	assign i14 = idx[3:0] + 4'd14;
	assign wx = w_q[i1];
	assign wy = w_q[i14];
	assign s0 = {wx[6:0], wx[31:7]} ^ {wx[17:0], wx[31:18]} ^ (wx >> 3);
	assign s1 = {wy[16:0], wy[31:17]} ^ {wy[18:0], wy[31:19]} ^ (wy >> 10);

	always_comb begin
		if (idx < 7'd16) begin
			wi = wnew;
		end else begin
			wi = w_q[i0] + s0 + w_q[i9] + s1;
		end
	end

	assign sig1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
		^ {v_q[4][24:0], v_q[4][31:25]};
	assign sig0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
		^ {v_q[0][21:0], v_q[0][31:22]};
	assign ch  = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
	assign maj = (v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1]));
	assign t1 = v_q[7] + sig1 + ch + round_k(idx) + wi;
	assign t2 = sig0 + maj;

	always_ff @(posedge clk) begin
		if (load) begin
			v_q <= chain_in;
		end else if (step) begin
			w_q[i0] <= wi;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign vars = v_q;
endmodule
